// File: rtl/sva_pkg.sv
`default_nettype none

package sva_pkg;

    // Width of the normalized magnitudes handed to the CORDIC.
    localparam int NORM_BITS = 30;

    // Width of the signed CORDIC x and y datapath, with headroom for the gain.
    localparam int XY_W = 34;

    // Width of the signed angle accumulator, radians in Q.24.
    localparam int Z_W = 28;

    // Width of the result angle, radians in Q3.13.
    localparam int ANGLE_W = 16;

    // Conversion from the Q.24 accumulator to the Q3.13 result.
    localparam int OUT_SHIFT  = 11;
    localparam int ROUND_BIAS = 1024;

    // Angle constants.
    localparam int ANGLE_PI_Q13 = 25736;
    localparam int HALF_PI_Q24  = 26353589;

    // Number of entries in the arctangent table.
    localparam int ATAN_LEN = 24;

    // Control flags that travel alongside the data through the pipeline.
    typedef struct packed {
        logic degen;   // either vector is zero length
        logic flat;    // cross product is exactly zero
        logic c_neg;   // cross product is negative
        logic d_neg;   // dot product is negative
    } sva_flags_t;

    // Arctangent table: round(atan(2^-i) * 2^24).
    function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            0:       val = Z_W'(13176795);
            1:       val = Z_W'(7778716);
            2:       val = Z_W'(4110060);
            3:       val = Z_W'(2086331);
            4:       val = Z_W'(1047214);
            5:       val = Z_W'(524117);
            6:       val = Z_W'(262123);
            7:       val = Z_W'(131069);
            8:       val = Z_W'(65536);
            9:       val = Z_W'(32768);
            10:      val = Z_W'(16384);
            11:      val = Z_W'(8192);
            12:      val = Z_W'(4096);
            13:      val = Z_W'(2048);
            14:      val = Z_W'(1024);
            15:      val = Z_W'(512);
            16:      val = Z_W'(256);
            17:      val = Z_W'(128);
            18:      val = Z_W'(64);
            19:      val = Z_W'(32);
            20:      val = Z_W'(16);
            21:      val = Z_W'(8);
            22:      val = Z_W'(4);
            23:      val = Z_W'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sva_front.sv
`default_nettype none

module sva_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] first_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2*COORD_WIDTH-1:0]           c_mag,
    output logic [2*COORD_WIDTH-1:0]           d_mag,
    output sva_pkg::sva_flags_t                flags
);
    import sva_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = 2 * COORD_WIDTH + 1;

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: capture the coordinates and flag a zero-length vector.
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic                degen1_reg;
    logic                degen1_next;

    assign degen1_next = ((first_x == '0) && (first_y == '0)) ||
                         ((second_x == '0) && (second_y == '0));

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            ax_reg     <= first_x;
            ay_reg     <= first_y;
            bx_reg     <= second_x;
            by_reg     <= second_y;
            degen1_reg <= degen1_next;
        end
    end

    // Stage 2: the four exact products, one multiplier each.
    logic signed [PW-1:0] p_ab_reg, p_ba_reg, p_xx_reg, p_yy_reg;
    logic                 degen2_reg;

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            p_ab_reg   <= PW'(ax_reg) * PW'(by_reg);
            p_ba_reg   <= PW'(bx_reg) * PW'(ay_reg);
            p_xx_reg   <= PW'(ax_reg) * PW'(bx_reg);
            p_yy_reg   <= PW'(ay_reg) * PW'(by_reg);
            degen2_reg <= degen1_reg;
        end
    end

    // Stage 3: cross and dot products, one bit wider than the products.
    logic signed [SW-1:0] cross_reg, dot_reg;
    logic                 degen3_reg;

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            cross_reg  <= SW'(p_ab_reg) - SW'(p_ba_reg);
            dot_reg    <= SW'(p_xx_reg) + SW'(p_yy_reg);
            degen3_reg <= degen2_reg;
        end
    end

    // Stage 4: split into sign and magnitude; a magnitude fits in PW bits.
    logic signed [SW-1:0] cross_abs, dot_abs;
    logic [PW-1:0]        c_mag_reg, d_mag_reg;
    sva_flags_t           flags_reg;
    sva_flags_t           flags_next;

    assign cross_abs = cross_reg[SW-1] ? -cross_reg : cross_reg;
    assign dot_abs   = dot_reg[SW-1] ? -dot_reg : dot_reg;

    always_comb begin
        flags_next.degen = degen3_reg;
        flags_next.flat  = (cross_reg == '0);
        flags_next.c_neg = cross_reg[SW-1];
        flags_next.d_neg = dot_reg[SW-1];
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            c_mag_reg <= cross_abs[PW-1:0];
            d_mag_reg <= dot_abs[PW-1:0];
            flags_reg <= flags_next;
        end
    end

    assign out_valid = v4_reg;
    assign c_mag     = c_mag_reg;
    assign d_mag     = d_mag_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

// File: rtl/sva_norm_cell.sv
`default_nettype none

module sva_norm_cell #(
    parameter int NW    = 32,
    parameter int SHIFT = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [NW-1:0]       c_in,
    input  wire logic [NW-1:0]       d_in,
    input  wire sva_pkg::sva_flags_t flags_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [NW-1:0]            c_out,
    output logic [NW-1:0]            d_out,
    output sva_pkg::sva_flags_t      flags_out
);
    import sva_pkg::*;

    logic          valid_reg;
    logic [NW-1:0] c_reg, d_reg, c_next, d_next;
    logic [NW-1:0] either;
    sva_flags_t    flags_reg;

    assign in_ready = !valid_reg || out_ready;

    // The leading one of the larger magnitude is the leading one of the OR of both.
    // Shift both left when the top SHIFT bits of that OR are all clear.
    assign either = c_in | d_in;

    always_comb begin
        if (either[NW-1 -: SHIFT] == '0) begin
            c_next = c_in << SHIFT;
            d_next = d_in << SHIFT;
        end else begin
            c_next = c_in;
            d_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            c_reg     <= c_next;
            d_reg     <= d_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign c_out     = c_reg;
    assign d_out     = d_reg;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

// File: rtl/sva_prerot.sv
`default_nettype none

module sva_prerot (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [sva_pkg::NORM_BITS-1:0]   c_mag,
    input  wire logic [sva_pkg::NORM_BITS-1:0]   d_mag,
    input  wire sva_pkg::sva_flags_t             flags_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [sva_pkg::XY_W-1:0]      x_out,
    output logic signed [sva_pkg::XY_W-1:0]      y_out,
    output logic signed [sva_pkg::Z_W-1:0]       z_out,
    output sva_pkg::sva_flags_t                  flags_out
);
    import sva_pkg::*;

    logic                   valid_reg;
    logic signed [XY_W-1:0] c_s, d_s, x_s, y_s;
    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    sva_flags_t             flags_reg;

    assign in_ready = !valid_reg || out_ready;

    // Rebuild signed x (dot) and y (cross) from sign and magnitude.
    assign c_s = $signed(XY_W'({1'b0, c_mag}));
    assign d_s = $signed(XY_W'({1'b0, d_mag}));
    assign x_s = flags_in.d_neg ? -d_s : d_s;
    assign y_s = flags_in.c_neg ? -c_s : c_s;

    // Vectors in the left half plane are turned by a quarter turn toward the x axis.
    always_comb begin
        x_next = x_s;
        y_next = y_s;
        z_next = '0;
        if (x_s < 0) begin
            if (y_s >= 0) begin
                x_next = y_s;
                y_next = -x_s;
                z_next = Z_W'(HALF_PI_Q24);
            end else begin
                x_next = -y_s;
                y_next = x_s;
                z_next = -Z_W'(HALF_PI_Q24);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

// File: rtl/sva_cordic_cell.sv
`default_nettype none

module sva_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [sva_pkg::XY_W-1:0] x_in,
    input  wire logic signed [sva_pkg::XY_W-1:0] y_in,
    input  wire logic signed [sva_pkg::Z_W-1:0]  z_in,
    input  wire sva_pkg::sva_flags_t           flags_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [sva_pkg::XY_W-1:0]    x_out,
    output logic signed [sva_pkg::XY_W-1:0]    y_out,
    output logic signed [sva_pkg::Z_W-1:0]     z_out,
    output sva_pkg::sva_flags_t                flags_out
);
    import sva_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q24(IDX);

    logic                   valid_reg;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    sva_flags_t             flags_reg;

    assign in_ready = !valid_reg || out_ready;

    // One vectoring micro-rotation: drive y toward zero, accumulate the angle.
    assign xs = x_in >>> IDX;
    assign ys = y_in >>> IDX;

    always_comb begin
        if (y_in >= 0) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_STEP;
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

// File: rtl/signed_vector_angle.sv
`default_nettype none

// Signed angle from a first 2D vector to a second one, as atan2(cross, dot) in
// radians (Q3.13, -pi..pi), using a fully pipelined vectoring CORDIC. One vector
// pair is taken every cycle while the output is not stalled; each pair passes
// through four front stages (capture, multiply, add, sign split), the log-step
// normalizer cells, the quarter-turn stage, one cell per CORDIC iteration and
// the output register. Every stage holds its own valid bit, so a stalled result
// only halts the stages behind it while bubbles ahead fill up.
// A zero-length input vector gives angle 0 with degenerate set; exactly parallel
// vectors give 0 and antiparallel ones give +pi.
module signed_vector_angle #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_first_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_first_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_second_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_second_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [sva_pkg::ANGLE_W-1:0] m_angle,
    output logic                               m_degenerate
);
    import sva_pkg::*;

    localparam int MAG_W = 2 * COORD_WIDTH;
    localparam int NW    = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
    localparam int NS    = $clog2(NW);
    localparam int NC    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    // Front end: products, cross and dot, sign and magnitude.
    logic             f_valid, f_ready;
    logic [MAG_W-1:0] f_c, f_d;
    sva_flags_t       f_flags;

    sva_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .first_x  (s_first_x),
        .first_y  (s_first_y),
        .second_x (s_second_x),
        .second_y (s_second_y),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .c_mag    (f_c),
        .d_mag    (f_d),
        .flags    (f_flags)
    );

    // Normalizer chain: each cell tries a left shift by half the previous one.
    logic [NW-1:0] n_c [NS+1];
    logic [NW-1:0] n_d [NS+1];
    sva_flags_t    n_flags [NS+1];
    logic          n_valid [NS+1];
    logic          n_ready [NS+1];

    assign n_c[0]     = NW'(f_c);
    assign n_d[0]     = NW'(f_d);
    assign n_flags[0] = f_flags;
    assign n_valid[0] = f_valid;
    assign f_ready    = n_ready[0];

    for (genvar k = 0; k < NS; k++) begin : g_norm
        sva_norm_cell #(
            .NW   (NW),
            .SHIFT(1 << (NS - 1 - k))
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (n_valid[k]),
            .in_ready (n_ready[k]),
            .c_in     (n_c[k]),
            .d_in     (n_d[k]),
            .flags_in (n_flags[k]),
            .out_valid(n_valid[k+1]),
            .out_ready(n_ready[k+1]),
            .c_out    (n_c[k+1]),
            .d_out    (n_d[k+1]),
            .flags_out(n_flags[k+1])
        );
    end

    // Quarter-turn stage on the top bits of the normalized magnitudes.
    logic signed [XY_W-1:0] c_x [NC+1];
    logic signed [XY_W-1:0] c_y [NC+1];
    logic signed [Z_W-1:0]  c_z [NC+1];
    sva_flags_t             c_flags [NC+1];
    logic                   c_valid [NC+1];
    logic                   c_ready [NC+1];

    sva_prerot u_prerot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (n_valid[NS]),
        .in_ready (n_ready[NS]),
        .c_mag    (n_c[NS][NW-1 -: NORM_BITS]),
        .d_mag    (n_d[NS][NW-1 -: NORM_BITS]),
        .flags_in (n_flags[NS]),
        .out_valid(c_valid[0]),
        .out_ready(c_ready[0]),
        .x_out    (c_x[0]),
        .y_out    (c_y[0]),
        .z_out    (c_z[0]),
        .flags_out(c_flags[0])
    );

    // CORDIC chain, one micro-rotation per cell.
    for (genvar i = 0; i < NC; i++) begin : g_cordic
        sva_cordic_cell #(
            .IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (c_valid[i]),
            .in_ready (c_ready[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .flags_in (c_flags[i]),
            .out_valid(c_valid[i+1]),
            .out_ready(c_ready[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1]),
            .flags_out(c_flags[i+1])
        );
    end

    // Output stage: round to Q3.13, saturate, and apply the special cases.
    logic                      out_valid_reg;
    logic                      out_en;
    logic signed [Z_W-1:0]     z_round, z_scaled;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic                      degen_reg;
    sva_flags_t                last_flags;

    assign last_flags = c_flags[NC];
    assign out_en     = !out_valid_reg || m_ready;
    assign c_ready[NC] = out_en;

    assign z_round  = c_z[NC] + Z_W'(ROUND_BIAS);
    assign z_scaled = z_round >>> OUT_SHIFT;

    always_comb begin
        if (last_flags.degen) begin
            angle_next = '0;
        end else if (last_flags.flat) begin
            angle_next = last_flags.d_neg ? ANGLE_W'(ANGLE_PI_Q13) : '0;
        end else if (z_scaled > Z_W'(ANGLE_PI_Q13)) begin
            angle_next = ANGLE_W'(ANGLE_PI_Q13);
        end else if (z_scaled < -Z_W'(ANGLE_PI_Q13)) begin
            angle_next = -ANGLE_W'(ANGLE_PI_Q13);
        end else begin
            angle_next = z_scaled[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= c_valid[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && c_valid[NC]) begin
            angle_reg <= angle_next;
            degen_reg <= last_flags.degen;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_angle      = angle_reg;
    assign m_degenerate = degen_reg;

endmodule

`default_nettype wire
